>>> src/ahsc_pkg.sv
// shared types and constants for the adaptive hash sample counter
package ahsc_pkg;

   localparam int unsigned TABLE_ENTRIES_DEF = 4096;
   localparam int unsigned NUM_LEVELS        = 64;
   localparam int unsigned LEVEL_W           = 6;
   localparam int unsigned THR_W             = 7;
   localparam int unsigned KEY_W             = 64;
   localparam int unsigned HIT_W             = 32;
   localparam int unsigned MAX_W             = 13;
   localparam int unsigned TZ_CELLS          = 8;
   localparam int unsigned TZ_SLICE          = 8;
   localparam logic [MAX_W-1:0] MAX_SAMPLES_RESET = 13'd4096;
   localparam logic [THR_W-1:0] THR_LIMIT         = 7'd64;

   // one table row
   typedef struct packed {
      logic               valid;
      logic [LEVEL_W-1:0] level;
      logic [HIT_W-1:0]   hits;
      logic [KEY_W-1:0]   key;
   } row_type;

   // link between neighboring trailing-zero cells
   typedef struct packed {
      logic       found;
      logic [6:0] count;
   } tz_link_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_L_DECIDE,
      ST_DROPCHK,
      ST_DROP,
      ST_FREESCAN,
      ST_F_DECIDE,
      ST_DONE
   } state_type;

endpackage

>>> src/ahsc_tz_cell.sv
// one cell of the trailing-zero chain, covers one byte of the hash
module ahsc_tz_cell (
   input  logic [ahsc_pkg::TZ_SLICE-1:0] slice,
   input  ahsc_pkg::tz_link_type         link_in,
   output ahsc_pkg::tz_link_type         link_out
);

   logic [3:0] tz_w;

   // trailing zeros inside this byte
   always_comb begin
      tz_w = 4'(ahsc_pkg::TZ_SLICE);
      for (int i = ahsc_pkg::TZ_SLICE - 1; i >= 0; i--) begin
         if (slice[i]) begin
            tz_w = 4'(i);
         end
      end
   end

   // pass on, or add this byte's zeros
   always_comb begin
      link_out = link_in;
      if (!link_in.found) begin
         link_out.count = link_in.count + 7'(tz_w);
         link_out.found = (slice != '0);
      end
   end

endmodule

>>> src/ahsc_table.sv
// sample table memory, one write port and one registered read port
module ahsc_table #(
   parameter int unsigned ENTRIES = ahsc_pkg::TABLE_ENTRIES_DEF,
   localparam int unsigned IDX_W  = $clog2(ENTRIES)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_addr,
   input  ahsc_pkg::row_type   wr_row,
   input  logic                rd_en,
   input  logic [IDX_W-1:0]    rd_addr,
   output ahsc_pkg::row_type   rd_row
);

   ahsc_pkg::row_type mem [ENTRIES];
   ahsc_pkg::row_type rd_row_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_row;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_row_ff <= mem[rd_addr];
      end
   end

   assign rd_row = rd_row_ff;

endmodule

>>> src/adaptive_hash_sample_counter.sv
// Adaptive hash sample counter: keeps a sampled table of distinct hashes whose
// trailing-zero level reaches a rising threshold, with saturating hit counts.
// An item whose hash is zero or below the threshold goes straight to the
// result. A sampled item scans the table memory one row a cycle through its
// single read port for a hit or a free row, and each dropped level adds a
// sweep of the table; a full table adds one more scan for a free row. After
// reset a clearing pass writes every row before the first item is taken. The
// level is found by a chain of eight byte cells.
module adaptive_hash_sample_counter #(
   parameter int unsigned TABLE_ENTRIES = ahsc_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [ahsc_pkg::KEY_W-1:0]  req_kmer_hash,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_sampled,
   output logic                        rsp_newly_inserted,
   output logic [ahsc_pkg::HIT_W-1:0]  rsp_entry_count,
   output logic [6:0]                  rsp_levels_dropped,
   output logic [ahsc_pkg::THR_W-1:0]  rsp_level_threshold,
   output logic [ahsc_pkg::MAX_W-1:0]  rsp_sample_total,
   output logic [63:0]                 rsp_kmers_seen,
   input  logic                        csr_wr_en,
   input  logic [ahsc_pkg::MAX_W-1:0]  csr_wr_data
);

   localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
   localparam int unsigned CNT_W = IDX_W + 1;
   localparam int unsigned CW    = (CNT_W > ahsc_pkg::MAX_W) ? CNT_W : ahsc_pkg::MAX_W;
   localparam logic [CNT_W-1:0] N_C  = CNT_W'(TABLE_ENTRIES);
   localparam logic [CW-1:0]    N_CW = CW'(TABLE_ENTRIES);

   // level of the incoming hash through the cell chain
   ahsc_pkg::tz_link_type link_w [ahsc_pkg::TZ_CELLS+1];
   assign link_w[0] = '0;
   for (genvar g = 0; g < ahsc_pkg::TZ_CELLS; g++) begin : g_tz
      ahsc_tz_cell u_cell (
         .slice   (req_kmer_hash[g*ahsc_pkg::TZ_SLICE +: ahsc_pkg::TZ_SLICE]),
         .link_in (link_w[g]),
         .link_out(link_w[g+1])
      );
   end
   logic [ahsc_pkg::LEVEL_W-1:0] lvl_w;
   assign lvl_w = link_w[ahsc_pkg::TZ_CELLS].count[ahsc_pkg::LEVEL_W-1:0];

   ahsc_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]             scan_ff, scan_in;
   logic                         rd_vld_ff, rd_last_ff;
   logic [IDX_W-1:0]             rd_idx_ff;
   logic [ahsc_pkg::KEY_W-1:0]   hash_ff, hash_in;
   logic [ahsc_pkg::LEVEL_W-1:0] lvl_ff, lvl_in;
   logic [ahsc_pkg::THR_W-1:0]   thr_ff, thr_in;
   logic [CNT_W-1:0]             smp_ff, smp_in;
   logic [63:0]                  kmers_ff, kmers_in;
   logic [ahsc_pkg::MAX_W-1:0]   max_ff, max_in;
   logic                         found_ff, found_in;
   logic [IDX_W-1:0]             found_idx_ff, found_idx_in;
   logic [ahsc_pkg::HIT_W-1:0]   found_cnt_ff, found_cnt_in;
   logic                         free_ok_ff, free_ok_in;
   logic [IDX_W-1:0]             free_idx_ff, free_idx_in;
   logic                         ins_after_ff, ins_after_in;
   logic                         res_smp_ff, res_smp_in;
   logic                         res_ins_ff, res_ins_in;
   logic [ahsc_pkg::HIT_W-1:0]   res_cnt_ff, res_cnt_in;
   logic [6:0]                   res_drop_ff, res_drop_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_load;

   logic                         issue;
   logic                         scanning;
   logic                         wr_en;
   logic [IDX_W-1:0]             wr_addr;
   ahsc_pkg::row_type            wr_row;
   ahsc_pkg::row_type            rd_row;
   logic [CW-1:0]                eff_max;
   logic                         over_max;
   logic [ahsc_pkg::HIT_W-1:0]   hit_next;

   ahsc_table #(.ENTRIES(TABLE_ENTRIES)) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_row (wr_row),
      .rd_en  (issue),
      .rd_addr(scan_ff[IDX_W-1:0]),
      .rd_row (rd_row)
   );

   // effective maximum and drop condition
   always_comb begin
      if (max_ff == '0) begin
         eff_max = CW'(1);
      end else if (CW'(max_ff) > N_CW) begin
         eff_max = N_CW;
      end else begin
         eff_max = CW'(max_ff);
      end
      over_max = (CW'(smp_ff) >= eff_max) && (thr_ff < ahsc_pkg::THR_LIMIT);
   end

   assign hit_next = (found_cnt_ff == '1) ? found_cnt_ff : found_cnt_ff + 1'b1;
   assign scanning = (state_ff == ahsc_pkg::ST_LOOKUP) || (state_ff == ahsc_pkg::ST_DROP) ||
                     (state_ff == ahsc_pkg::ST_FREESCAN);
   assign issue    = scanning && (scan_ff < N_C);
   assign req_stall = (state_ff != ahsc_pkg::ST_IDLE);

   // sequencer: next state and datapath updates
   always_comb begin
      state_in     = state_ff;
      scan_in      = issue ? scan_ff + 1'b1 : scan_ff;
      hash_in      = hash_ff;
      lvl_in       = lvl_ff;
      thr_in       = thr_ff;
      smp_in       = smp_ff;
      kmers_in     = kmers_ff;
      max_in       = csr_wr_en ? csr_wr_data : max_ff;
      found_in     = found_ff;
      found_idx_in = found_idx_ff;
      found_cnt_in = found_cnt_ff;
      free_ok_in   = free_ok_ff;
      free_idx_in  = free_idx_ff;
      ins_after_in = ins_after_ff;
      res_smp_in   = res_smp_ff;
      res_ins_in   = res_ins_ff;
      res_cnt_in   = res_cnt_ff;
      res_drop_in  = res_drop_ff;
      rsp_load     = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = rd_idx_ff;
      wr_row       = '0;
      unique case (state_ff)
         ahsc_pkg::ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = scan_ff[IDX_W-1:0];
            scan_in = scan_ff + 1'b1;
            if (scan_ff == N_C - 1'b1) begin
               state_in = ahsc_pkg::ST_IDLE;
            end
         end
         ahsc_pkg::ST_IDLE: begin
            if (req_valid) begin
               kmers_in    = kmers_ff + 1'b1;
               hash_in     = req_kmer_hash;
               lvl_in      = lvl_w;
               res_smp_in  = 1'b0;
               res_ins_in  = 1'b0;
               res_cnt_in  = '0;
               res_drop_in = '0;
               found_in    = 1'b0;
               free_ok_in  = 1'b0;
               scan_in     = '0;
               if (req_kmer_hash == '0 || thr_ff == ahsc_pkg::THR_LIMIT ||
                   {1'b0, lvl_w} < thr_ff) begin
                  state_in = ahsc_pkg::ST_DONE;
               end else begin
                  state_in = ahsc_pkg::ST_LOOKUP;
               end
            end
         end
         ahsc_pkg::ST_LOOKUP: begin
            if (rd_vld_ff) begin
               if (rd_row.valid && rd_row.key == hash_ff) begin
                  found_in     = 1'b1;
                  found_idx_in = rd_idx_ff;
                  found_cnt_in = rd_row.hits;
               end
               if (!rd_row.valid && !free_ok_ff) begin
                  free_ok_in  = 1'b1;
                  free_idx_in = rd_idx_ff;
               end
               if (rd_last_ff) begin
                  state_in = ahsc_pkg::ST_L_DECIDE;
               end
            end
         end
         ahsc_pkg::ST_L_DECIDE: begin
            ins_after_in = 1'b0;
            if (found_ff) begin
               wr_en      = 1'b1;
               wr_addr    = found_idx_ff;
               wr_row     = '{valid: 1'b1, level: lvl_ff, hits: hit_next, key: hash_ff};
               res_smp_in = 1'b1;
               res_cnt_in = hit_next;
               state_in   = ahsc_pkg::ST_DONE;
            end else if (free_ok_ff) begin
               wr_en        = 1'b1;
               wr_addr      = free_idx_ff;
               wr_row       = '{valid: 1'b1, level: lvl_ff, hits: 32'd1, key: hash_ff};
               smp_in       = smp_ff + 1'b1;
               res_smp_in   = 1'b1;
               res_ins_in   = 1'b1;
               res_cnt_in   = 32'd1;
               ins_after_in = 1'b1;
               state_in     = ahsc_pkg::ST_DROPCHK;
            end else begin
               state_in = ahsc_pkg::ST_DROPCHK;
            end
         end
         ahsc_pkg::ST_DROPCHK: begin
            scan_in = '0;
            if (over_max) begin
               state_in = ahsc_pkg::ST_DROP;
            end else if (ins_after_ff) begin
               state_in = ahsc_pkg::ST_DONE;
            end else begin
               free_ok_in = 1'b0;
               state_in   = ahsc_pkg::ST_FREESCAN;
            end
         end
         ahsc_pkg::ST_DROP: begin
            if (rd_vld_ff) begin
               if (rd_row.valid && rd_row.level == thr_ff[ahsc_pkg::LEVEL_W-1:0]) begin
                  wr_en       = 1'b1;
                  wr_row      = rd_row;
                  wr_row.valid = 1'b0;
                  smp_in      = smp_ff - 1'b1;
               end
               if (rd_last_ff) begin
                  thr_in      = thr_ff + 1'b1;
                  res_drop_in = res_drop_ff + 1'b1;
                  state_in    = ahsc_pkg::ST_DROPCHK;
               end
            end
         end
         ahsc_pkg::ST_FREESCAN: begin
            if (rd_vld_ff) begin
               if (!rd_row.valid && !free_ok_ff) begin
                  free_ok_in  = 1'b1;
                  free_idx_in = rd_idx_ff;
               end
               if (rd_last_ff) begin
                  state_in = ahsc_pkg::ST_F_DECIDE;
               end
            end
         end
         ahsc_pkg::ST_F_DECIDE: begin
            if (free_ok_ff && {1'b0, lvl_ff} >= thr_ff) begin
               wr_en        = 1'b1;
               wr_addr      = free_idx_ff;
               wr_row       = '{valid: 1'b1, level: lvl_ff, hits: 32'd1, key: hash_ff};
               smp_in       = smp_ff + 1'b1;
               res_smp_in   = 1'b1;
               res_ins_in   = 1'b1;
               res_cnt_in   = 32'd1;
               ins_after_in = 1'b1;
               state_in     = ahsc_pkg::ST_DROPCHK;
            end else begin
               state_in = ahsc_pkg::ST_DONE;
            end
         end
         ahsc_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ahsc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ahsc_pkg::ST_IDLE;
         end
      endcase
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ahsc_pkg::ST_CLEAR;
         scan_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         rd_last_ff   <= 1'b0;
         thr_ff       <= '0;
         smp_ff       <= '0;
         kmers_ff     <= '0;
         max_ff       <= ahsc_pkg::MAX_SAMPLES_RESET;
         found_ff     <= 1'b0;
         free_ok_ff   <= 1'b0;
         ins_after_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         rd_vld_ff    <= issue;
         rd_last_ff   <= issue && (scan_ff == N_C - 1'b1);
         thr_ff       <= thr_in;
         smp_ff       <= smp_in;
         kmers_ff     <= kmers_in;
         max_ff       <= max_in;
         found_ff     <= found_in;
         free_ok_ff   <= free_ok_in;
         ins_after_ff <= ins_after_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff    <= scan_ff[IDX_W-1:0];
      hash_ff      <= hash_in;
      lvl_ff       <= lvl_in;
      found_idx_ff <= found_idx_in;
      found_cnt_ff <= found_cnt_in;
      free_idx_ff  <= free_idx_in;
      res_smp_ff   <= res_smp_in;
      res_ins_ff   <= res_ins_in;
      res_cnt_ff   <= res_cnt_in;
      res_drop_ff  <= res_drop_in;
      if (rsp_load) begin
         rsp_sampled         <= res_smp_ff;
         rsp_newly_inserted  <= res_ins_ff;
         rsp_entry_count     <= res_cnt_ff;
         rsp_levels_dropped  <= res_drop_ff;
         rsp_level_threshold <= thr_ff;
         rsp_sample_total    <= ahsc_pkg::MAX_W'(smp_ff);
         rsp_kmers_seen      <= kmers_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // sample count never exceeds the table size
   a_smp_bound: assert property (@(posedge clock) disable iff (reset)
      smp_ff <= N_C) else $error("sample count above table size");

   // a level sweep only runs below the top level
   a_drop_thr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ahsc_pkg::ST_DROP) |-> (thr_ff < ahsc_pkg::THR_LIMIT))
      else $error("drop sweep with threshold at top");

   // an accepted item goes to lookup or straight to the result
   a_accept_next: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=>
         (state_ff == ahsc_pkg::ST_LOOKUP || state_ff == ahsc_pkg::ST_DONE))
      else $error("bad state after accept");

   // a result is loaded only when the output register is free
   a_rsp_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> $stable(rsp_entry_count))
      else $error("result overwritten while stalled");

endmodule
